// ===== rtl/core/pfa_pkg.sv =====
// Package for the page frame allocator: sizes, operation and status codes.
// Used by page_frame_allocator_top; depends on nothing else.
package pfa_pkg;

  // Number of page frames handled by the allocator.
  localparam int unsigned NPAGE   = 16384;
  localparam int unsigned PAGE_W  = 14;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned DEPTH_W = 15;
  localparam int unsigned OP_W    = 3;
  localparam int unsigned STAT_W  = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Operation codes carried in the op field.
  localparam logic [OP_W-1:0] OP_ALLOC  = 3'd0;
  localparam logic [OP_W-1:0] OP_INCREF = 3'd1;
  localparam logic [OP_W-1:0] OP_DECREF = 3'd2;
  localparam logic [OP_W-1:0] OP_FREE   = 3'd3;
  localparam logic [OP_W-1:0] OP_INIT   = 3'd4;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOMEM     = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;

endpackage

// ===== rtl/core/pfa_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Stand-alone; used for the count memory and the free stack of the allocator.
module pfa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/page_frame_allocator_top.sv =====
// Page frame allocator top level: per-page reference counts and a LIFO free list.
// Depends on pfa_pkg and pfa_ram.

// The allocator keeps a 16-bit reference count for each of NPAGE page frames in one
// RAM and a last-in-first-out stack of free page numbers in a second RAM. After reset
// a clearing pass writes every count to zero, during which no item is accepted. An
// item is then handled one at a time; incref and decref update the count RAM with a
// read-modify-write. Incref, decref, free and the unused codes read the count and then
// emit; alloc first reads the popped page number from the stack, since it must be read
// before its count can be read, and alloc on an empty stack goes straight to its result.
// The result appears in the same cycle in which the next item can be accepted. Init
// rewrites every count and rebuilds the stack, one page per cycle. The result sits in
// an output register; the next item is accepted while it waits to be taken, and
// processing stalls only when a new result is ready before the old one has gone.
module page_frame_allocator_top (
  input  logic        clk,
  input  logic        rst,
  // Configuration: reserved_pages.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [14:0] cfg_data,
  // Input items.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [2:0] op, [16:3] page, [23:17] zero
  // Result items.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // [1:0] status, [15:2] page_out,
                                      // [31:16] ref_count, [46:32] free_count, [47] zero
);

  localparam int unsigned PAGE_W  = pfa_pkg::PAGE_W;
  localparam int unsigned CNT_W   = pfa_pkg::CNT_W;
  localparam int unsigned DEPTH_W = pfa_pkg::DEPTH_W;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_STACK_WAIT, S_CNT_WAIT, S_SWEEP, S_EMIT
  } state_t;

  state_t                    state;
  logic [pfa_pkg::OP_W-1:0]  op_r;
  logic [PAGE_W-1:0]         page_r;
  logic [DEPTH_W-1:0]        depth;
  logic [PAGE_W-1:0]         idx;
  logic [DEPTH_W-1:0]        bound;
  logic [DEPTH_W-1:0]        reserved_pages;
  logic [pfa_pkg::STAT_W-1:0] res_status;
  logic [PAGE_W-1:0]         res_page;
  logic [CNT_W-1:0]          res_cnt;

  // Input field views.
  logic [pfa_pkg::OP_W-1:0] in_op;
  logic [PAGE_W-1:0]        in_page;
  logic                     in_accept;
  assign in_op     = s_axis_tdata[2:0];
  assign in_page   = s_axis_tdata[16:3];
  assign in_accept = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;

  // The output register is loaded when a result is ready and the old one is gone.
  logic emit;
  assign emit = (state == S_EMIT) && (!m_axis_tvalid || m_axis_tready);

  // Memory ports.
  logic              cnt_we, cnt_re;
  logic [PAGE_W-1:0] cnt_waddr, cnt_raddr;
  logic [CNT_W-1:0]  cnt_wdata, cnt_rdata;
  logic              stk_we, stk_re;
  logic [PAGE_W-1:0] stk_waddr, stk_raddr;
  logic [PAGE_W-1:0] stk_wdata, stk_rdata;

  pfa_ram #(.WIDTH(CNT_W), .DEPTH(pfa_pkg::NPAGE)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (cnt_re),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  pfa_ram #(.WIDTH(PAGE_W), .DEPTH(pfa_pkg::NPAGE)) u_stk_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // The stack has room while its depth is below NPAGE.
  logic stack_room;
  assign stack_room = (depth < DEPTH_W'(pfa_pkg::NPAGE));

  // Reserved boundary clamped to the number of pages.
  logic [DEPTH_W-1:0] bound_clamped;
  assign bound_clamped = (reserved_pages > DEPTH_W'(pfa_pkg::NPAGE)) ?
                         DEPTH_W'(pfa_pkg::NPAGE) : reserved_pages;

  logic idx_reserved;
  assign idx_reserved = ({1'b0, idx} < bound);

  // Memory control and the updated count, decoded from the state.
  logic [CNT_W-1:0] cnt_res;
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = idx;
    cnt_wdata = '0;
    cnt_re    = 1'b0;
    cnt_raddr = in_page;
    stk_we    = 1'b0;
    stk_waddr = depth[PAGE_W-1:0];
    stk_wdata = page_r;
    stk_re    = 1'b0;
    stk_raddr = PAGE_W'(depth - DEPTH_W'(1));
    cnt_res   = cnt_rdata;
    case (state)
      S_CLEAR: begin
        cnt_we = 1'b1;
      end
      S_IDLE: begin
        if (in_accept) begin
          if (in_op == pfa_pkg::OP_ALLOC) begin
            stk_re = (depth != '0);
          end else if (in_op != pfa_pkg::OP_INIT) begin
            cnt_re = 1'b1;
          end
        end
      end
      S_STACK_WAIT: begin
        cnt_re    = 1'b1;
        cnt_raddr = stk_rdata;
      end
      S_CNT_WAIT: begin
        cnt_waddr = page_r;
        case (op_r)
          pfa_pkg::OP_INCREF: begin
            if (cnt_rdata != pfa_pkg::CNT_MAX) begin
              cnt_res = cnt_rdata + CNT_W'(1);
            end
            cnt_we    = 1'b1;
            cnt_wdata = cnt_res;
          end
          pfa_pkg::OP_DECREF: begin
            if (cnt_rdata != '0) begin
              cnt_res   = cnt_rdata - CNT_W'(1);
              cnt_we    = 1'b1;
              cnt_wdata = cnt_res;
              stk_we    = (cnt_res == '0) && stack_room;
            end
          end
          pfa_pkg::OP_FREE: begin
            stk_we = (cnt_rdata == '0) && stack_room;
          end
          default: begin
          end
        endcase
      end
      S_SWEEP: begin
        // Reserved pages get count one, the rest count zero and a stack entry.
        cnt_we    = 1'b1;
        cnt_wdata = idx_reserved ? CNT_W'(1) : '0;
        stk_we    = !idx_reserved && stack_room;
        stk_wdata = idx;
      end
      default: begin
      end
    endcase
  end

  // Sequencer, state registers and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      idx            <= '0;
      depth          <= '0;
      reserved_pages <= '0;
      m_axis_tvalid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        reserved_pages <= cfg_data;
      end
      if (emit) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          idx <= idx + PAGE_W'(1);
          if (idx == {PAGE_W{1'b1}}) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_accept) begin
            op_r       <= in_op;
            page_r     <= in_page;
            res_page   <= in_page;
            res_status <= pfa_pkg::ST_OK;
            if (in_op == pfa_pkg::OP_ALLOC) begin
              if (depth == '0) begin
                res_status <= pfa_pkg::ST_NOMEM;
                res_page   <= '0;
                res_cnt    <= '0;
                state      <= S_EMIT;
              end else begin
                depth <= depth - DEPTH_W'(1);
                state <= S_STACK_WAIT;
              end
            end else if (in_op == pfa_pkg::OP_INIT) begin
              bound <= bound_clamped;
              idx   <= '0;
              depth <= '0;
              state <= S_SWEEP;
            end else begin
              state <= S_CNT_WAIT;
            end
          end
        end
        S_STACK_WAIT: begin
          res_page <= stk_rdata;
          state    <= S_CNT_WAIT;
        end
        S_CNT_WAIT: begin
          res_cnt <= cnt_res;
          if (op_r == pfa_pkg::OP_DECREF && cnt_rdata == '0) begin
            res_status <= pfa_pkg::ST_UNDERFLOW;
          end
          if (stk_we) begin
            depth <= depth + DEPTH_W'(1);
          end
          state <= S_EMIT;
        end
        S_SWEEP: begin
          idx <= idx + PAGE_W'(1);
          if (stk_we) begin
            depth <= depth + DEPTH_W'(1);
          end
          if (idx == {PAGE_W{1'b1}}) begin
            res_cnt <= ({1'b0, page_r} < bound) ? CNT_W'(1) : '0;
            state   <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit) begin
            m_axis_tdata <= {1'b0, depth, res_cnt, res_page, res_status};
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The free stack never holds more than NPAGE entries.
  assert property (@(posedge clk) disable iff (rst)
    depth <= DEPTH_W'(pfa_pkg::NPAGE))
    else $error("free stack depth beyond page count");

  // The clearing pass runs over every page before items are taken.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR && idx != {PAGE_W{1'b1}}) |=> (state == S_CLEAR))
    else $error("clearing pass ended early");

  // An underflow result always reports a count of zero.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[1:0] == pfa_pkg::ST_UNDERFLOW)
      |-> (m_axis_tdata[31:16] == '0))
    else $error("underflow with nonzero count");

  // A failed alloc is only reported with an empty free list.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[1:0] == pfa_pkg::ST_NOMEM)
      |-> (m_axis_tdata[46:32] == '0))
    else $error("no-memory status with free pages left");

endmodule

// ===== bench/pfa_scoreboard_pkg.sv =====
// Scoreboard for the page frame allocator bench: result layout and the allocator predictor.
// Depends on pfa_pkg for sizes, operation codes and status codes.
`timescale 1ns / 1ps
package pfa_scoreboard_pkg;

  // Unused operation codes, which only report the count of the page.
  localparam logic [pfa_pkg::OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [pfa_pkg::OP_W-1:0] OP_SPARE_LAST  = 3'd7;

  // Result fields, declared from the top bit down so a cast of the low 47 bits of
  // m_axis_tdata fills them directly.
  typedef struct packed {
    logic [pfa_pkg::DEPTH_W-1:0] free_count;
    logic [pfa_pkg::CNT_W-1:0]   ref_count;
    logic [pfa_pkg::PAGE_W-1:0]  page;
    logic [pfa_pkg::STAT_W-1:0]  status;
  } pfa_result_t;

  class page_alloc_scoreboard;
    logic [pfa_pkg::CNT_W-1:0]  page_refs [pfa_pkg::NPAGE];
    logic [pfa_pkg::PAGE_W-1:0] free_stack [pfa_pkg::NPAGE];
    int unsigned                stack_top;
    int unsigned                reserved;
    pfa_result_t                owed_results [$];
    logic [pfa_pkg::PAGE_W-1:0] handed_out [$];
    int unsigned                errors;

    // Counts are cleared by the pass after reset; the stack starts empty.
    function new();
      foreach (page_refs[i]) page_refs[i] = '0;
      stack_top = 0;
      reserved  = 0;
      errors    = 0;
    endfunction

    function void set_reserved(input logic [pfa_pkg::DEPTH_W-1:0] value);
      reserved = 32'(value);
    endfunction

    function int unsigned pending();
      return owed_results.size();
    endfunction

    // A push onto a full stack is dropped.
    function void push_free(input logic [pfa_pkg::PAGE_W-1:0] pg);
      if (stack_top < pfa_pkg::NPAGE) begin
        free_stack[stack_top] = pg;
        stack_top++;
      end
    endfunction

    // Init: low pages are held with count 1, the rest are pushed in ascending order.
    function void rebuild();
      int unsigned bound;
      bound = (reserved > pfa_pkg::NPAGE) ? pfa_pkg::NPAGE : reserved;
      stack_top = 0;
      for (int unsigned i = 0; i < pfa_pkg::NPAGE; i++) begin
        if (i < bound) begin
          page_refs[i] = pfa_pkg::CNT_W'(1);
        end else begin
          page_refs[i] = '0;
          push_free(pfa_pkg::PAGE_W'(i));
        end
      end
    endfunction

    // Work out the result of one accepted item and queue it.
    function void note_item(input logic [pfa_pkg::OP_W-1:0] op,
                            input logic [pfa_pkg::PAGE_W-1:0] pg);
      pfa_result_t want;
      want.status    = pfa_pkg::ST_OK;
      want.page      = pg;
      want.ref_count = '0;
      case (op)
        pfa_pkg::OP_ALLOC: begin
          if (stack_top == 0) begin
            want.status = pfa_pkg::ST_NOMEM;
            want.page   = '0;
          end else begin
            stack_top--;
            want.page      = free_stack[stack_top];
            want.ref_count = page_refs[want.page];
            handed_out.push_back(want.page);
            if (handed_out.size() > 64) void'(handed_out.pop_front());
          end
        end
        pfa_pkg::OP_INCREF: begin
          if (page_refs[pg] != pfa_pkg::CNT_MAX) page_refs[pg]++;
          want.ref_count = page_refs[pg];
        end
        pfa_pkg::OP_DECREF: begin
          if (page_refs[pg] == 0) begin
            want.status = pfa_pkg::ST_UNDERFLOW;
          end else begin
            page_refs[pg]--;
            if (page_refs[pg] == 0) push_free(pg);
          end
          want.ref_count = page_refs[pg];
        end
        pfa_pkg::OP_FREE: begin
          if (page_refs[pg] == 0) push_free(pg);
          want.ref_count = page_refs[pg];
        end
        pfa_pkg::OP_INIT: begin
          rebuild();
          want.ref_count = page_refs[pg];
        end
        default: begin
          want.ref_count = page_refs[pg];
        end
      endcase
      want.free_count = pfa_pkg::DEPTH_W'(stack_top);
      owed_results.push_back(want);
    endfunction

    // Pages recently handed out are favored so that counts move away from zero.
    function logic [pfa_pkg::PAGE_W-1:0] pick_page();
      if (handed_out.size() == 0 || $urandom_range(0, 3) == 0)
        return pfa_pkg::PAGE_W'($urandom_range(0, pfa_pkg::NPAGE - 1));
      return handed_out[$urandom_range(0, handed_out.size() - 1)];
    endfunction

    // Four-state compare, so an unknown bit on the output counts as a mismatch.
    function void check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    // Compare one accepted result with the oldest expectation.
    function void check_result(input logic [47:0] data);
      pfa_result_t want;
      pfa_result_t got;
      if (owed_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, expected none, actual %h",
                 $time, data);
        return;
      end
      want = owed_results.pop_front();
      got  = pfa_result_t'(data[46:0]);
      check_field("status", 32'(want.status), 32'(got.status));
      check_field("page_out", 32'(want.page), 32'(got.page));
      check_field("ref_count", 32'(want.ref_count), 32'(got.ref_count));
      check_field("free_count", 32'(want.free_count), 32'(got.free_count));
    endfunction
  endclass

endpackage

// ===== bench/page_frame_allocator_top_tb.sv =====
// Bench top for page_frame_allocator_top: drives items and register writes, checks results.
// Depends on pfa_pkg, pfa_scoreboard_pkg and the allocator RTL.
`timescale 1ns / 1ps
module page_frame_allocator_top_tb;

  localparam int unsigned IDLE_PCT     = 27;
  localparam int unsigned RANDOM_ITEMS = 1400;
  localparam int unsigned PHASES       = 6;
  localparam int unsigned TAIL_CYCLES  = 32;
  localparam int unsigned BURST_ITEMS  = 32;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [pfa_pkg::DEPTH_W-1:0]  cfg_data = '0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [23:0]                  s_axis_tdata = '0;   // [2:0] op, [16:3] page, [23:17] zero
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [47:0]                  m_axis_tdata;        // [1:0] status, [15:2] page_out,
                                                     // [31:16] ref_count, [46:32] free_count
  bit                           idle_on = 1'b1;
  pfa_scoreboard_pkg::page_alloc_scoreboard board;

  page_frame_allocator_top u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The result side stalls at random while idling is enabled.
  always @(posedge clk) begin
    m_axis_tready <= !rst && (!idle_on || $urandom_range(0, 99) >= IDLE_PCT);
  end

  // Every accepted result goes to the scoreboard.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
  end

  // Present one item, with random gaps ahead of it, and hold it until it is taken.
  task automatic send_item(input logic [pfa_pkg::OP_W-1:0] op,
                           input logic [pfa_pkg::PAGE_W-1:0] pg);
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, pg, op};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    board.note_item(op, pg);
  endtask

  // Wait until every expected result is back, plus a short tail.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Write reserved_pages once the allocator has gone quiet.
  task automatic write_reserved(input logic [pfa_pkg::DEPTH_W-1:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    board.set_reserved(value);
  endtask

  // One random item: mostly alloc and count traffic, init only now and then.
  task automatic random_item();
    int unsigned                roll;
    logic [pfa_pkg::OP_W-1:0]   op;
    roll = $urandom_range(0, 999);
    if (roll < 5)        op = pfa_pkg::OP_INIT;
    else if (roll < 300) op = pfa_pkg::OP_ALLOC;
    else if (roll < 560) op = pfa_pkg::OP_INCREF;
    else if (roll < 820) op = pfa_pkg::OP_DECREF;
    else if (roll < 960) op = pfa_pkg::OP_FREE;
    else op = pfa_pkg::OP_W'($urandom_range(pfa_scoreboard_pkg::OP_SPARE_FIRST,
                                            pfa_scoreboard_pkg::OP_SPARE_LAST));
    send_item(op, board.pick_page());
  endtask

  // Main sequence.
  initial begin
    logic [pfa_pkg::DEPTH_W-1:0] setting;
    logic [pfa_pkg::PAGE_W-1:0]  hot_page;
    board = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Before any init: empty stack and all counts zero.
    write_reserved(pfa_pkg::DEPTH_W'(pfa_pkg::NPAGE));
    send_item(pfa_pkg::OP_ALLOC, '0);
    send_item(pfa_pkg::OP_DECREF, '1);
    send_item(pfa_pkg::OP_INCREF, '0);
    send_item(pfa_pkg::OP_FREE, '0);
    send_item(pfa_pkg::OP_DECREF, '0);
    send_item(pfa_pkg::OP_FREE, '0);
    send_item(pfa_pkg::OP_ALLOC, '1);
    send_item(pfa_pkg::OP_ALLOC, '0);
    send_item(pfa_pkg::OP_ALLOC, '0);
    send_item(pfa_scoreboard_pkg::OP_SPARE_FIRST, 14'h2AAA);
    send_item(pfa_scoreboard_pkg::OP_SPARE_LAST, 14'h1555);

    // Every page reserved, so the stack stays empty until a page drops to zero.
    send_item(pfa_pkg::OP_INIT, '1);
    send_item(pfa_pkg::OP_ALLOC, '0);
    send_item(pfa_pkg::OP_DECREF, '1);
    send_item(pfa_pkg::OP_ALLOC, '0);

    // Nothing reserved: the stack is full and further pushes are dropped.
    write_reserved('0);
    send_item(pfa_pkg::OP_INIT, '0);
    send_item(pfa_pkg::OP_FREE, 14'd5);
    send_item(pfa_pkg::OP_DECREF, 14'd7);
    send_item(pfa_pkg::OP_ALLOC, '0);
    send_item(pfa_pkg::OP_FREE, '1);
    send_item(pfa_pkg::OP_INCREF, '1);

    // Boundary past the last page, then drive one count up at full rate.
    write_reserved('1);
    hot_page = pfa_pkg::PAGE_W'($urandom_range(0, pfa_pkg::NPAGE - 1));
    send_item(pfa_pkg::OP_INIT, hot_page);
    idle_on = 1'b0;
    repeat (BURST_ITEMS) send_item(pfa_pkg::OP_INCREF, hot_page);
    send_item(pfa_pkg::OP_DECREF, hot_page);
    send_item(pfa_pkg::OP_INCREF, hot_page);
    idle_on = 1'b1;

    // Random traffic under several boundary settings; the first phase runs with no
    // idling on either side.
    for (int unsigned p = 0; p < PHASES; p++) begin
      case (p)
        0:       setting = '0;
        1:       setting = pfa_pkg::DEPTH_W'(pfa_pkg::NPAGE - 1);
        2:       setting = pfa_pkg::DEPTH_W'(1);
        default: setting = pfa_pkg::DEPTH_W'($urandom_range(2, pfa_pkg::NPAGE - 2));
      endcase
      write_reserved(setting);
      idle_on = (p != 0);
      send_item(pfa_pkg::OP_INIT, board.pick_page());
      repeat (RANDOM_ITEMS / PHASES) random_item();
    end
    idle_on = 1'b1;

    settle();
    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: a run that has not finished in time is reported as failed; the slowest
  // correct run is dominated by the clearing pass and the init sweeps.
  initial begin
    #30_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/pfa_pkg.sv
rtl/core/pfa_ram.sv
rtl/core/page_frame_allocator_top.sv
bench/pfa_scoreboard_pkg.sv
bench/page_frame_allocator_top_tb.sv
